// File: hw/rtl/wsfd_pkg.sv
package wsfd_pkg;

    localparam logic [15:0] CFG_TIMEOUT_RESET  = 16'd10000;
    localparam logic [15:0] CFG_CAPACITY_RESET = 16'd1024;

    localparam logic [7:0] CFG_IDX_TIMEOUT  = 8'd0;
    localparam logic [7:0] CFG_IDX_CAPACITY = 8'd1;

    localparam logic [7:0] OP_TEXT   = 8'h81;
    localparam logic [7:0] OP_BINARY = 8'h82;
    localparam logic [7:0] OP_PING   = 8'h89;
    localparam logic [7:0] OP_PONG   = 8'h8a;

    localparam logic [7:0] LEN_MAX_SHORT = 8'd125;
    localparam logic [7:0] LEN_CODE_EXT  = 8'd126;

    localparam logic [1:0] TYPE_TEXT   = 2'd0;
    localparam logic [1:0] TYPE_BINARY = 2'd1;
    localparam logic [1:0] TYPE_PING   = 2'd2;
    localparam logic [1:0] TYPE_PONG   = 2'd3;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_LEN    = 3'd1,
        PH_EXT_HI = 3'd2,
        PH_EXT_LO = 3'd3,
        PH_BODY   = 3'd4,
        PH_DROP   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        K_IDLE    = 3'd0,
        K_BYTE    = 3'd1,
        K_END     = 3'd2,
        K_ERROR   = 3'd3,
        K_DROP    = 3'd4,
        K_TIMEOUT = 3'd5
    } kind_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] buffer_capacity;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        kind_t       kind;
        logic [1:0]  frame_type;
        logic        first_of_frame;
        logic [16:0] frame_length;
    } res_t;

endpackage

// File: hw/rtl/websocket_frame_delimiter_unit.sv
// An accepted item's result is registered and shown on the output register in the next cycle.
// Throughput: 1 item per cycle; the input is taken whenever the output register
// is empty or its result is being taken in the same cycle.
// Reset (rst_n, asynchronous, active low): no result pending, first byte
// expected, all counters cleared, timeout_ticks = 10000, buffer_capacity = 1024.
module websocket_frame_delimiter_unit
    import wsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  data_byte,
    input  logic        chunk_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [2:0]  kind,
    output logic [1:0]  frame_type,
    output logic        first_of_frame,
    output logic [16:0] frame_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    wsfd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    wsfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .func      (func),
        .data_byte (data_byte),
        .chunk_end (chunk_end),
        .cfg       (cfg),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = res_reg.out_byte;
    assign kind           = res_reg.kind;
    assign frame_type     = res_reg.frame_type;
    assign first_of_frame = res_reg.first_of_frame;
    assign frame_length   = res_reg.frame_length;

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted item gave no result");

    a_len_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == K_END) |-> (frame_length >= 17'd2))
        else $error("frame end with short length");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != K_END) |-> (frame_length == 17'd0))
        else $error("length outside frame end");

endmodule

// File: hw/rtl/wsfd_cfg.sv
module wsfd_cfg
    import wsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [7:0]  wr_index,
    input  logic [15:0] wr_data,
    output cfg_t        cfg
);

    logic [15:0] timeout_ticks_reg;
    logic [15:0] buffer_capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg   <= CFG_TIMEOUT_RESET;
            buffer_capacity_reg <= CFG_CAPACITY_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_IDX_TIMEOUT:  timeout_ticks_reg   <= wr_data;
                CFG_IDX_CAPACITY: buffer_capacity_reg <= wr_data;
                default:          ;
            endcase
        end
    end

    assign cfg.timeout_ticks   = timeout_ticks_reg;
    assign cfg.buffer_capacity = buffer_capacity_reg;

endmodule

// File: hw/rtl/wsfd_core.sv
module wsfd_core
    import wsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       func,
    input  logic [7:0] data_byte,
    input  logic       chunk_end,
    input  cfg_t       cfg,
    output res_t       res
);

    phase_t      phase_reg,        phase_next;
    logic [1:0]  current_type_reg, current_type_next;
    logic [7:0]  ext_len_high_reg, ext_len_high_next;
    logic [15:0] bytes_left_reg,   bytes_left_next;
    logic [16:0] byte_count_reg,   byte_count_next;
    logic [16:0] total_length_reg, total_length_next;
    logic [15:0] timer_count_reg,  timer_count_next;
    logic        timer_running_reg, timer_running_next;

    logic        cap_zero;
    logic        cap_full;
    logic        first_ok;
    logic [1:0]  first_type;
    logic [15:0] ext_len;
    logic [15:0] left_dec;
    logic        timer_expire;
    phase_t      after_err;

    assign cap_zero     = (cfg.buffer_capacity == 16'd0);
    assign cap_full     = (byte_count_reg >= {1'b0, cfg.buffer_capacity});
    assign first_ok     = data_byte inside {OP_TEXT, OP_BINARY, OP_PING, OP_PONG};
    assign ext_len      = {ext_len_high_reg, data_byte};
    assign left_dec     = (bytes_left_reg != 16'd0) ? bytes_left_reg - 16'd1 : bytes_left_reg;
    assign timer_expire = timer_running_reg && (timer_count_reg <= 16'd1);
    assign after_err    = chunk_end ? PH_FIRST : PH_DROP;

    always_comb
    begin
        case (data_byte)
            OP_TEXT:   first_type = TYPE_TEXT;
            OP_BINARY: first_type = TYPE_BINARY;
            OP_PING:   first_type = TYPE_PING;
            default:   first_type = TYPE_PONG;
        endcase
    end

    // next state
    always_comb
    begin
        logic idle_all;
        idle_all           = 1'b0;
        phase_next         = phase_reg;
        current_type_next  = current_type_reg;
        ext_len_high_next  = ext_len_high_reg;
        bytes_left_next    = bytes_left_reg;
        byte_count_next    = byte_count_reg;
        total_length_next  = total_length_reg;
        timer_count_next   = timer_count_reg;
        timer_running_next = timer_running_reg;

        if (func)
        begin
            if (timer_expire)
            begin
                idle_all   = 1'b1;
                phase_next = PH_FIRST;
            end
            else if (timer_running_reg)
                timer_count_next = timer_count_reg - 16'd1;
        end
        else if (phase_reg == PH_DROP)
        begin
            if (chunk_end)
                phase_next = PH_FIRST;
        end
        else if (phase_reg == PH_FIRST)
        begin
            if (!cap_zero)
            begin
                if (first_ok)
                begin
                    current_type_next  = first_type;
                    byte_count_next    = 17'd1;
                    timer_count_next   = cfg.timeout_ticks;
                    timer_running_next = 1'b1;
                    phase_next         = PH_LEN;
                end
                else
                begin
                    idle_all   = 1'b1;
                    phase_next = after_err;
                end
            end
        end
        else if (!cap_full)
        begin
            byte_count_next = byte_count_reg + 17'd1;
            case (phase_reg)
                PH_LEN:
                begin
                    if (current_type_reg[1])
                    begin
                        idle_all   = 1'b1;
                        if (data_byte == 8'd0)
                        begin
                            total_length_next = 17'd2;
                            phase_next        = PH_FIRST;
                        end
                        else
                            phase_next = after_err;
                    end
                    else if (data_byte <= LEN_MAX_SHORT)
                    begin
                        total_length_next = {9'd0, data_byte} + 17'd2;
                        if (data_byte == 8'd0)
                        begin
                            idle_all   = 1'b1;
                            phase_next = PH_FIRST;
                        end
                        else
                        begin
                            bytes_left_next = {8'd0, data_byte};
                            phase_next      = PH_BODY;
                        end
                    end
                    else if (data_byte == LEN_CODE_EXT)
                        phase_next = PH_EXT_HI;
                    else
                    begin
                        idle_all   = 1'b1;
                        phase_next = after_err;
                    end
                end
                PH_EXT_HI:
                begin
                    ext_len_high_next = data_byte;
                    phase_next        = PH_EXT_LO;
                end
                PH_EXT_LO:
                begin
                    total_length_next = {1'b0, ext_len} + 17'd4;
                    if (ext_len == 16'd0)
                    begin
                        idle_all   = 1'b1;
                        phase_next = PH_FIRST;
                    end
                    else
                    begin
                        bytes_left_next = ext_len;
                        phase_next      = PH_BODY;
                    end
                end
                default:
                begin
                    bytes_left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        idle_all   = 1'b1;
                        phase_next = PH_FIRST;
                    end
                end
            endcase
        end

        if (idle_all)
        begin
            byte_count_next    = 17'd0;
            bytes_left_next    = 16'd0;
            timer_running_next = 1'b0;
            timer_count_next   = 16'd0;
        end
    end

    // result
    always_comb
    begin
        res.out_byte       = func ? 8'd0 : data_byte;
        res.kind           = K_BYTE;
        res.frame_type     = current_type_next;
        res.first_of_frame = 1'b0;
        res.frame_length   = 17'd0;

        if (func)
            res.kind = timer_expire ? K_TIMEOUT : K_IDLE;
        else if (phase_reg == PH_DROP)
            res.kind = K_DROP;
        else if (phase_reg == PH_FIRST)
        begin
            if (cap_zero)
                res.kind = K_DROP;
            else if (first_ok)
                res.first_of_frame = 1'b1;
            else
                res.kind = K_ERROR;
        end
        else if (cap_full)
            res.kind = K_DROP;
        else
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (current_type_reg[1] || data_byte <= LEN_MAX_SHORT)
                    begin
                        if (data_byte == 8'd0)
                        begin
                            res.kind         = K_END;
                            res.frame_length = 17'd2;
                        end
                        else if (current_type_reg[1])
                            res.kind = K_ERROR;
                    end
                    else if (data_byte != LEN_CODE_EXT)
                        res.kind = K_ERROR;
                end
                PH_EXT_HI: ;
                PH_EXT_LO:
                begin
                    if (ext_len == 16'd0)
                    begin
                        res.kind         = K_END;
                        res.frame_length = 17'd4;
                    end
                end
                default:
                begin
                    if (left_dec == 16'd0)
                    begin
                        res.kind         = K_END;
                        res.frame_length = total_length_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_FIRST;
            current_type_reg  <= 2'd0;
            ext_len_high_reg  <= 8'd0;
            bytes_left_reg    <= 16'd0;
            byte_count_reg    <= 17'd0;
            total_length_reg  <= 17'd0;
            timer_count_reg   <= 16'd0;
            timer_running_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            current_type_reg  <= current_type_next;
            ext_len_high_reg  <= ext_len_high_next;
            bytes_left_reg    <= bytes_left_next;
            byte_count_reg    <= byte_count_next;
            total_length_reg  <= total_length_next;
            timer_count_reg   <= timer_count_next;
            timer_running_reg <= timer_running_next;
        end
    end

    // a frame in progress always has its timer armed
    a_timer_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN || phase_reg == PH_EXT_HI || phase_reg == PH_EXT_LO
         || phase_reg == PH_BODY) |-> timer_running_reg)
        else $error("timer not running inside a frame");

    a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (bytes_left_reg != 16'd0))
        else $error("payload phase with no bytes left");

    a_first_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.first_of_frame) |=> (phase_reg == PH_LEN && byte_count_reg == 17'd1))
        else $error("first byte did not open a frame");

endmodule

// File: test/websocket_frame_delimiter_unit_test.sv
`timescale 1ns / 100ps

module websocket_frame_delimiter_unit_test;

    import wsfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned REPORT_LIMIT = 200;
    localparam int          NUM_PHASES   = 8;

    typedef struct {
        logic       tick;
        logic [7:0] data;
        logic       seg_end;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        func = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        chunk_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic [2:0]  kind;
    logic [1:0]  frame_type;
    logic        first_of_frame;
    logic [16:0] frame_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // deframer state as predicted
    phase_t      ph = PH_FIRST;
    logic [1:0]  cur_type = TYPE_TEXT;
    logic [7:0]  ext_hi = '0;
    logic [16:0] bytes_left = '0;
    logic [16:0] byte_cnt = '0;
    logic [16:0] total_len = '0;
    logic [15:0] tmr_cnt = '0;
    logic        tmr_on = 1'b0;
    logic [15:0] tmo_ticks = CFG_TIMEOUT_RESET;
    logic [15:0] capacity = CFG_CAPACITY_RESET;

    stim_t       pending_q[$];
    res_t        result_q[$];
    stim_t       nxt_item;
    res_t        want;
    int unsigned items_queued = 0;
    int unsigned items_checked = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_cnt = 0;
    logic        in_fire = 1'b0;
    logic        cfg_fire = 1'b0;
    logic        calm = 1'b0;
    int unsigned tick_pct = 0;
    int unsigned gen_tmo = CFG_TIMEOUT_RESET;

    websocket_frame_delimiter_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .data_byte      (data_byte),
        .chunk_end      (chunk_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .kind           (kind),
        .frame_type     (frame_type),
        .first_of_frame (first_of_frame),
        .frame_length   (frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void frame_close(input phase_t nxt);
        ph = nxt;
        byte_cnt = '0;
        bytes_left = '0;
        tmr_on = 1'b0;
        tmr_cnt = '0;
    endfunction

    function automatic res_t delimit_step(input logic is_tick, input logic [7:0] b,
                                          input logic seg_end);
        res_t   r;
        phase_t err_ph;
        logic [16:0] ext_len;
        r.out_byte = b;
        r.kind = K_BYTE;
        r.first_of_frame = 1'b0;
        r.frame_length = '0;
        err_ph = seg_end ? PH_FIRST : PH_DROP;
        ext_len = {1'b0, ext_hi, b};
        if (is_tick)
        begin
            r.out_byte = '0;
            r.kind = K_IDLE;
            if (tmr_on)
            begin
                if (tmr_cnt <= 16'd1)
                begin
                    r.kind = K_TIMEOUT;
                    frame_close(PH_FIRST);
                end
                else
                    tmr_cnt = tmr_cnt - 16'd1;
            end
        end
        else if (ph == PH_DROP)
        begin
            r.kind = K_DROP;
            if (seg_end)
                ph = PH_FIRST;
        end
        else if (ph == PH_FIRST)
        begin
            if (capacity == '0)
                r.kind = K_DROP;
            else if (b == OP_TEXT || b == OP_BINARY || b == OP_PING || b == OP_PONG)
            begin
                if (b == OP_TEXT)
                    cur_type = TYPE_TEXT;
                else if (b == OP_BINARY)
                    cur_type = TYPE_BINARY;
                else if (b == OP_PING)
                    cur_type = TYPE_PING;
                else
                    cur_type = TYPE_PONG;
                byte_cnt = 17'd1;
                r.first_of_frame = 1'b1;
                tmr_cnt = tmo_ticks;
                tmr_on = 1'b1;
                ph = PH_LEN;
            end
            else
            begin
                r.kind = K_ERROR;
                frame_close(err_ph);
            end
        end
        else if (byte_cnt >= {1'b0, capacity})
            r.kind = K_DROP;
        else
        begin
            byte_cnt = byte_cnt + 17'd1;
            case (ph)
                PH_LEN:
                begin
                    if (cur_type == TYPE_PING || cur_type == TYPE_PONG)
                    begin
                        if (b == 8'd0)
                        begin
                            r.kind = K_END;
                            r.frame_length = 17'd2;
                            total_len = 17'd2;
                            frame_close(PH_FIRST);
                        end
                        else
                        begin
                            r.kind = K_ERROR;
                            frame_close(err_ph);
                        end
                    end
                    else if (b <= LEN_MAX_SHORT)
                    begin
                        total_len = {9'd0, b} + 17'd2;
                        if (b == 8'd0)
                        begin
                            r.kind = K_END;
                            r.frame_length = 17'd2;
                            frame_close(PH_FIRST);
                        end
                        else
                        begin
                            bytes_left = {9'd0, b};
                            ph = PH_BODY;
                        end
                    end
                    else if (b == LEN_CODE_EXT)
                        ph = PH_EXT_HI;
                    else
                    begin
                        r.kind = K_ERROR;
                        frame_close(err_ph);
                    end
                end
                PH_EXT_HI:
                begin
                    ext_hi = b;
                    ph = PH_EXT_LO;
                end
                PH_EXT_LO:
                begin
                    total_len = ext_len + 17'd4;
                    if (ext_len == '0)
                    begin
                        r.kind = K_END;
                        r.frame_length = 17'd4;
                        frame_close(PH_FIRST);
                    end
                    else
                    begin
                        bytes_left = ext_len;
                        ph = PH_BODY;
                    end
                end
                default:
                begin
                    if (bytes_left != '0)
                        bytes_left = bytes_left - 17'd1;
                    if (bytes_left == '0)
                    begin
                        r.kind = K_END;
                        r.frame_length = total_len;
                        frame_close(PH_FIRST);
                    end
                end
            endcase
        end
        r.frame_type = cur_type;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, exp_val, got_val);
        end
    endtask

    // checker, predictor and watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            in_fire = rst_n && in_valid && in_ready;
            cfg_fire = rst_n && cfg_valid && cfg_ready;
            if (rst_n && out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected item, expected none, got byte %0h kind %0d",
                                 $time, out_byte, kind);
                end
                else
                begin
                    want = result_q.pop_front();
                    items_checked++;
                    check_field("out_byte", want.out_byte, out_byte);
                    check_field("kind", want.kind, kind);
                    check_field("frame_type", want.frame_type, frame_type);
                    check_field("first_of_frame", want.first_of_frame, first_of_frame);
                    check_field("frame_length", want.frame_length, frame_length);
                end
            end
            if (cfg_fire)
            begin
                if (cfg_index == CFG_IDX_TIMEOUT)
                    tmo_ticks = cfg_data;
                else if (cfg_index == CFG_IDX_CAPACITY)
                    capacity = cfg_data;
            end
            if (in_fire)
                result_q.push_back(delimit_step(func, data_byte, chunk_end));
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 8))
            begin
                nxt_item = pending_q.pop_front();
                in_valid <= 1'b1;
                func <= nxt_item.tick;
                data_byte <= nxt_item.data;
                chunk_end <= nxt_item.seg_end;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 8);
    end

    task automatic push_item(input logic tick, input logic [7:0] b, input logic seg_end);
        stim_t s;
        s.tick = tick;
        s.data = b;
        s.seg_end = seg_end;
        pending_q.push_back(s);
        items_queued++;
    endtask

    task automatic push_tick();
        push_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // data byte, sometimes preceded by a tick
    task automatic send(input logic [7:0] b, input logic seg_end);
        if ($urandom_range(99) < tick_pct)
            push_tick();
        push_item(1'b0, b, seg_end);
    endtask

    function automatic logic seg_flag(input bit last);
        if (last)
            return $urandom_range(1) == 1;
        return $urandom_range(9) == 0;
    endfunction

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(3))
            0: return OP_TEXT;
            1: return OP_BINARY;
            2: return OP_PING;
            default: return OP_PONG;
        endcase
    endfunction

    task automatic random_frame();
        int unsigned sel;
        int unsigned len;
        int unsigned n;
        logic [7:0]  op;
        logic [7:0]  b;
        sel = $urandom_range(99);
        op = pick_opcode();
        if (sel < 70)
        begin
            send(op, seg_flag(0));
            if (op == OP_PING || op == OP_PONG)
                len = 0;
            else
            begin
                n = $urandom_range(99);
                if (n < 55)
                    len = $urandom_range(20);
                else if (n < 70)
                    len = $urandom_range(125, 100);
                else if (n < 93)
                    len = $urandom_range(40);
                else
                    len = $urandom_range(300, 126);
            end
            if (n >= 70 && op != OP_PING && op != OP_PONG)
            begin
                send(LEN_CODE_EXT, seg_flag(0));
                send(8'(len >> 8), seg_flag(0));
                send(8'(len), seg_flag(len == 0));
            end
            else
                send(8'(len), seg_flag(len == 0));
            for (int i = 0; i < int'(len); i++)
                send(8'($urandom_range(255)), seg_flag(i == int'(len) - 1));
        end
        else if (sel < 80)
        begin
            // bad first byte, rest of the segment
            do
                b = 8'($urandom_range(255));
            while (b == OP_TEXT || b == OP_BINARY || b == OP_PING || b == OP_PONG);
            n = $urandom_range(4);
            send(b, (n == 0) ? 1'($urandom_range(1)) : 1'b0);
            for (int i = 0; i < int'(n); i++)
                send(8'($urandom_range(255)), i == int'(n) - 1);
        end
        else if (sel < 88)
        begin
            // illegal length
            send(op, 1'b0);
            if (op == OP_PING || op == OP_PONG)
                b = 8'($urandom_range(255, 1));
            else
                b = 8'($urandom_range(255, 127));
            n = $urandom_range(3);
            send(b, (n == 0) ? 1'($urandom_range(1)) : 1'b0);
            for (int i = 0; i < int'(n); i++)
                send(8'($urandom_range(255)), i == int'(n) - 1);
        end
        else if (sel < 95)
        begin
            // unfinished frame, left to time out
            send($urandom_range(1) ? OP_TEXT : OP_BINARY, 1'b0);
            if ($urandom_range(1))
            begin
                send(LEN_CODE_EXT, 1'b0);
                send(8'($urandom_range(255)), seg_flag(0));
                send(8'($urandom_range(255, 16)), seg_flag(0));
            end
            else
                send(8'($urandom_range(125, 8)), seg_flag(0));
            n = $urandom_range(5);
            for (int i = 0; i < int'(n); i++)
                send(8'($urandom_range(255)), seg_flag(0));
            if (gen_tmo <= 64)
                for (int i = 0; i < ((gen_tmo == 0) ? 1 : int'(gen_tmo)); i++)
                    push_tick();
        end
        else
        begin
            n = $urandom_range(6, 1);
            for (int i = 0; i < int'(n); i++)
                push_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
        end
    endtask

    task automatic drain();
        while (items_checked != items_queued)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic reg_write(input logic [7:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] tmo_set [NUM_PHASES];
        logic [15:0] cap_set [NUM_PHASES];
        int unsigned len_set [NUM_PHASES];
        int unsigned start;

        tmo_set = '{16'd5, 16'd0, 16'd65535, 16'd1, 16'd40, 16'd10000, 16'd0, 16'd0};
        cap_set = '{16'd6, 16'd0, 16'd65535, 16'd2, 16'd300, 16'd1024, 16'd0, 16'd0};
        len_set = '{200, 60, 250, 150, 250, 200, 100, 100};
        tmo_set[6] = 16'($urandom_range(80, 1));
        cap_set[6] = 16'($urandom_range(400, 2));
        tmo_set[7] = 16'($urandom_range(20, 2));
        cap_set[7] = 16'($urandom_range(40, 3));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed items at reset settings
        push_item(1'b0, OP_TEXT, 1'b0);
        push_item(1'b0, 8'h00, 1'b1);
        push_item(1'b0, OP_BINARY, 1'b0);
        push_item(1'b0, 8'h01, 1'b0);
        push_item(1'b0, 8'hff, 1'b0);
        push_item(1'b0, OP_PING, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, OP_PONG, 1'b0);
        push_item(1'b0, 8'h00, 1'b1);
        push_item(1'b0, OP_TEXT, 1'b0);
        push_item(1'b0, LEN_CODE_EXT, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, OP_BINARY, 1'b0);
        push_item(1'b0, LEN_CODE_EXT, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'h02, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'hff, 1'b1);
        push_item(1'b1, 8'hff, 1'b1);
        push_item(1'b0, 8'h00, 1'b1);
        push_item(1'b0, 8'hff, 1'b0);
        push_item(1'b1, 8'h00, 1'b0);
        push_item(1'b0, OP_TEXT, 1'b1);
        push_item(1'b0, OP_TEXT, 1'b0);
        push_item(1'b0, 8'h7f, 1'b0);
        push_item(1'b0, 8'h55, 1'b1);
        push_item(1'b0, OP_PING, 1'b0);
        push_item(1'b0, 8'h05, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            reg_write(CFG_IDX_TIMEOUT, tmo_set[p]);
            reg_write(CFG_IDX_CAPACITY, cap_set[p]);
            if (p == 2)
            begin
                // out-of-range indexes are ignored
                reg_write(8'hff, 16'h0000);
                reg_write(8'd2, 16'($urandom_range(65535)));
            end
            gen_tmo = tmo_set[p];
            tick_pct = (tmo_set[p] <= 64) ? 5 : 2;
            calm <= (p == 4);
            start = items_queued;
            while (items_queued - start < len_set[p])
                random_frame();
        end

        drain();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && result_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
